// ===== rtl/core/skc_pkg.sv =====
// Shared types and constants for the solid k-mer coverage island unit.
// Used by skc_cell, skc_tap and solid_kmer_coverage_island_unit; no dependencies.
`default_nettype none

package skc_pkg;

    // Sizing
    localparam int MAX_KMER_DEF = 63;
    localparam int LANES        = 8;
    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = 64;
    localparam int CFG_DATA_W   = 8;

    // Register indexes of the configuration port
    localparam logic [0:0] CFG_KMER_LEN  = 1'b0;
    localparam logic [0:0] CFG_MIN_COUNT = 1'b1;

    // Reset values and limits
    localparam logic [5:0]  KMER_LEN_RST  = 6'd33;
    localparam logic [7:0]  MIN_COUNT_RST = 8'd3;
    localparam logic [5:0]  COVER_MAX     = 6'h3f;
    localparam logic [5:0]  RUN6_MAX      = 6'h3f;
    localparam logic [15:0] RUN16_MAX     = 16'hffff;
    localparam logic [2:0]  BASE_AMBIG    = 3'd4;

    // One pending base: coverage counts and flags of the k-mer ending there
    typedef struct packed {
        logic [5:0] lcov;
        logic [5:0] hcov;
        logic       solid;
        logic       high;
    } cell_t;

    // Controls broadcast to every cell of the chain
    typedef struct packed {
        logic step;      // shift one place down the chain
        logic clear;     // drop all contents (end of read)
        logic inc_low;   // add a solid k-mer to covered cells
        logic inc_high;  // add a solid and high k-mer to covered cells
    } cell_ctl_t;

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/solid_kmer_coverage_island_unit.sv =====
// Top level of the solid k-mer coverage island unit: control, run and island
// tracking, chain of skc_cell, tap skc_tap, output register. Uses skc_pkg.
//
//  channel | ports                          | word
//  --------+--------------------------------+------------------------------------
//  config  | cfg_wr_en/_index/_data         | kmer_len (0), min_count (1)
//  input   | s_tvalid/s_tready/s_tdata/tlast| one base with its k-mer counts
//  result  | m_tvalid/m_tready/m_tdata/tlast| coverage of one base, island at end
//
// One base is taken per cycle while no flush runs and the result channel does
// not stall. Its result, if any, passes the tap register at the accepting edge
// and then the output register. A base marked tlast is followed by a flush
// when k, kmer_len with zero read as one, is above one. Each flush step shifts
// the cell chain one place and holds off the input. Reset is synchronous and
// clears all cells at once. A stalled result word freezes the whole pipeline
// and the input.
`default_nettype none

module solid_kmer_coverage_island_unit #(
    parameter int MAX_KMER = skc_pkg::MAX_KMER_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration write
    input  wire logic                             cfg_wr_en,
    input  wire logic [0:0]                       cfg_wr_index,
    input  wire logic [skc_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // input words
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // base_code[2:0], kmer_found[3], kmer_count[11:4], kmer_high_count[17:12]
    input  wire logic [skc_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire logic                             s_tlast,    // read_end
    // result words
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // position[15:0], low_cover[21:16], high_cover[27:22], solid_flag[28],
    // high_flag[29], island_found[30], island_start[46:31], island_end[63:47]
    output logic [skc_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic                                  m_tlast     // last_result
);
    import skc_pkg::*;

    // Configuration
    logic [5:0] kmer_len_reg;
    logic [7:0] min_count_reg;
    logic [5:0] k_eff;
    logic [5:0] tap_idx;

    // Per-read tracking
    logic [5:0]  valid_run_reg, valid_run_next;
    logic [15:0] base_index_reg, base_index_next;
    logic [15:0] solid_run_reg, solid_run_next;
    logic [15:0] best_run_reg, best_run_next;
    logic [16:0] best_end_reg, best_end_next;
    logic [5:0]  seen_reg, seen_next;

    // Flush bookkeeping
    state_t      state_reg, state_next;
    logic [5:0]  flush_d_reg, flush_d_next;
    logic [5:0]  start_reg, start_next;
    logic [15:0] cur_reg, cur_next;
    logic        isl_found_reg, isl_found_next;
    logic [15:0] isl_start_reg, isl_start_next;
    logic [16:0] isl_end_reg, isl_end_next;

    // Tap stage
    logic        s1_valid_reg, s1_valid_next;
    logic [15:0] s1_pos_reg, s1_pos_next;
    logic        s1_last_reg, s1_last_next;
    logic        s1_found_reg, s1_found_next;
    logic [15:0] s1_start_reg, s1_start_next;
    logic [16:0] s1_end_reg, s1_end_next;

    // Output stage
    logic        m_valid_reg;
    logic        out_last_reg;
    logic [15:0] out_pos_reg;
    cell_t       out_cell_reg;
    logic        out_found_reg;
    logic [15:0] out_start_reg;
    logic [16:0] out_end_reg;

    // Chain
    cell_ctl_t              cell_ctl;
    cell_t                  left0;
    cell_t [MAX_KMER-1:0]   cell_q;
    cell_t [MAX_KMER-1:0]   cell_upd;
    cell_t [LANES-1:0]      cand;

    // Input fields and handshake
    logic [2:0]  in_base;
    logic        in_found;
    logic [7:0]  in_count;
    logic [5:0]  in_hcount;
    logic        stall;
    logic        adv;
    logic        accept;

    // Per-base decisions
    logic        base_ok;
    logic [5:0]  vrun_new;
    logic        gate;
    logic        new_solid;
    logic        new_high;
    logic [15:0] srun_new;
    logic [15:0] best1;
    logic [16:0] bend1;
    logic [15:0] best_fin;
    logic [16:0] bend_fin;
    logic [5:0]  seen_new;
    logic        emit_now;
    logic [5:0]  start_v;
    logic        isl_found_v;
    logic [16:0] isl_start_full;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_len_reg  <= KMER_LEN_RST;
            min_count_reg <= MIN_COUNT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_KMER_LEN:  kmer_len_reg  <= cfg_wr_data[5:0];
                CFG_MIN_COUNT: min_count_reg <= cfg_wr_data[7:0];
            endcase
        end
    end

    // Effective k: zero reads as one, clamp to the chain length
    always_comb begin
        k_eff = (kmer_len_reg == 6'd0) ? 6'd1 : kmer_len_reg;
        if (k_eff > 6'(MAX_KMER)) begin
            k_eff = 6'(MAX_KMER);
        end
    end
    assign tap_idx = k_eff - 6'd1;

    // Unpack the input word
    assign in_base   = s_tdata[2:0];
    assign in_found  = s_tdata[3];
    assign in_count  = s_tdata[11:4];
    assign in_hcount = s_tdata[17:12];

    // Handshake: a waiting result word freezes everything
    assign stall    = m_valid_reg && !m_tready;
    assign adv      = !stall;
    assign s_tready = adv && (state_reg == ST_RUN);
    assign accept   = s_tvalid && s_tready;

    // Classify the k-mer ending at this base
    always_comb begin
        base_ok  = (in_base < BASE_AMBIG);
        vrun_new = !base_ok ? 6'd0 :
                   (valid_run_reg == RUN6_MAX) ? RUN6_MAX : valid_run_reg + 6'd1;
        gate      = base_ok && (vrun_new >= k_eff) && in_found;
        new_solid = gate && (in_count >= min_count_reg);
        new_high  = gate && ({3'b000, in_hcount} >= ({1'b0, min_count_reg} + 9'd1));
    end

    // Track solid runs and the longest island
    always_comb begin
        if (new_solid) begin
            srun_new = (solid_run_reg == RUN16_MAX) ? RUN16_MAX : solid_run_reg + 16'd1;
        end else begin
            srun_new = 16'd0;
        end
        best1 = best_run_reg;
        bend1 = best_end_reg;
        if (!new_solid && (solid_run_reg > best_run_reg)) begin
            best1 = solid_run_reg;
            bend1 = {1'b0, base_index_reg};
        end
        best_fin = best1;
        bend_fin = bend1;
        if (srun_new > best1) begin
            best_fin = srun_new;
            bend_fin = {1'b0, base_index_reg} + 17'd1;
        end
        isl_found_v    = (best_fin != 16'd0);
        isl_start_full = bend_fin - {1'b0, best_fin} - {11'b0, k_eff} + 17'd1;
        seen_new = (seen_reg == RUN6_MAX) ? RUN6_MAX : seen_reg + 6'd1;
        emit_now = (seen_new >= k_eff);
        start_v  = emit_now ? tap_idx : seen_new;
    end

    // Next state, chain controls and tap stage contents
    always_comb begin
        state_next      = state_reg;
        flush_d_next    = flush_d_reg;
        start_next      = start_reg;
        cur_next        = cur_reg;
        isl_found_next  = isl_found_reg;
        isl_start_next  = isl_start_reg;
        isl_end_next    = isl_end_reg;
        valid_run_next  = valid_run_reg;
        base_index_next = base_index_reg;
        solid_run_next  = solid_run_reg;
        best_run_next   = best_run_reg;
        best_end_next   = best_end_reg;
        seen_next       = seen_reg;
        s1_valid_next   = s1_valid_reg;
        s1_pos_next     = s1_pos_reg;
        s1_last_next    = s1_last_reg;
        s1_found_next   = s1_found_reg;
        s1_start_next   = s1_start_reg;
        s1_end_next     = s1_end_reg;
        cell_ctl        = '0;
        left0           = '0;

        unique case (state_reg)
            ST_RUN: begin
                if (accept) begin
                    cell_ctl.step     = 1'b1;
                    cell_ctl.inc_low  = new_solid;
                    cell_ctl.inc_high = new_solid && new_high;
                    left0.solid       = new_solid;
                    left0.high        = new_high;

                    s1_valid_next = emit_now;
                    s1_pos_next   = base_index_reg - {10'b0, tap_idx};
                    s1_last_next  = s_tlast && (start_v == 6'd0);
                    s1_found_next = s1_last_next && isl_found_v;
                    s1_start_next = (s1_last_next && isl_found_v) ? isl_start_full[15:0] : 16'd0;
                    s1_end_next   = (s1_last_next && isl_found_v) ? bend_fin : 17'd0;

                    if (s_tlast) begin
                        // Latch what the flush needs, drop per-read state
                        cur_next        = base_index_reg;
                        start_next      = start_v;
                        flush_d_next    = k_eff - 6'd2;
                        isl_found_next  = isl_found_v;
                        isl_start_next  = isl_found_v ? isl_start_full[15:0] : 16'd0;
                        isl_end_next    = isl_found_v ? bend_fin : 17'd0;
                        valid_run_next  = 6'd0;
                        base_index_next = 16'd0;
                        solid_run_next  = 16'd0;
                        best_run_next   = 16'd0;
                        best_end_next   = 17'd0;
                        seen_next       = 6'd0;
                        if (start_v == 6'd0) begin
                            cell_ctl.clear = 1'b1;
                        end else begin
                            state_next = ST_FLUSH;
                        end
                    end else begin
                        valid_run_next  = vrun_new;
                        base_index_next = base_index_reg + 16'd1;
                        solid_run_next  = srun_new;
                        best_run_next   = best1;
                        best_end_next   = bend1;
                        seen_next       = seen_new;
                    end
                end else if (adv) begin
                    s1_valid_next = 1'b0;
                end
            end
            ST_FLUSH: begin
                if (adv) begin
                    // Shift the chain so the next younger base reaches the tap
                    cell_ctl.step = 1'b1;
                    s1_valid_next = (flush_d_reg < start_reg);
                    s1_pos_next   = cur_reg - {10'b0, flush_d_reg};
                    s1_last_next  = (flush_d_reg == 6'd0);
                    s1_found_next = s1_last_next && isl_found_reg;
                    s1_start_next = s1_last_next ? isl_start_reg : 16'd0;
                    s1_end_next   = s1_last_next ? isl_end_reg : 17'd0;
                    if (flush_d_reg == 6'd0) begin
                        cell_ctl.clear = 1'b1;
                        state_next     = ST_RUN;
                    end else begin
                        flush_d_next = flush_d_reg - 6'd1;
                    end
                end
            end
        endcase
    end

    // Control and tracking registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_RUN;
            flush_d_reg    <= 6'd0;
            start_reg      <= 6'd0;
            valid_run_reg  <= 6'd0;
            base_index_reg <= 16'd0;
            solid_run_reg  <= 16'd0;
            best_run_reg   <= 16'd0;
            best_end_reg   <= 17'd0;
            seen_reg       <= 6'd0;
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            flush_d_reg    <= flush_d_next;
            start_reg      <= start_next;
            valid_run_reg  <= valid_run_next;
            base_index_reg <= base_index_next;
            solid_run_reg  <= solid_run_next;
            best_run_reg   <= best_run_next;
            best_end_reg   <= best_end_next;
            seen_reg       <= seen_next;
            s1_valid_reg   <= s1_valid_next;
            if (adv) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers of the flush bookkeeping, tap and output stages
    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        isl_found_reg <= isl_found_next;
        isl_start_reg <= isl_start_next;
        isl_end_reg   <= isl_end_next;
        s1_pos_reg    <= s1_pos_next;
        s1_last_reg   <= s1_last_next;
        s1_found_reg  <= s1_found_next;
        s1_start_reg  <= s1_start_next;
        s1_end_reg    <= s1_end_next;
        if (adv) begin
            out_last_reg  <= s1_last_reg;
            out_pos_reg   <= s1_pos_reg;
            out_cell_reg  <= cand[tap_idx[2:0]];
            out_found_reg <= s1_found_reg;
            out_start_reg <= s1_start_reg;
            out_end_reg   <= s1_end_reg;
        end
    end

    // Chain of cells, newest base at cell zero
    for (genvar i = 0; i < MAX_KMER; i++) begin : g_cell
        if (i == 0) begin : g_head
            skc_cell #(.IDX(i)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (cell_ctl),
                .k_eff   (k_eff),
                .left    (left0),
                .upd     (cell_upd[i]),
                .q       (cell_q[i])
            );
        end else begin : g_body
            skc_cell #(.IDX(i)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (cell_ctl),
                .k_eff   (k_eff),
                .left    (cell_q[i-1]),
                .upd     (cell_upd[i]),
                .q       (cell_q[i])
            );
        end
    end

    // Group select of the tap
    skc_tap #(.MAX_KMER(MAX_KMER)) u_tap (
        .aclk  (aclk),
        .en    (adv),
        .grp   (tap_idx[5:3]),
        .cells (cell_upd),
        .cand  (cand)
    );

    // Drive the result channel
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_end_reg, out_start_reg, out_found_reg, out_cell_reg.high,
                       out_cell_reg.solid, out_cell_reg.hcov, out_cell_reg.lcov,
                       out_pos_reg};

    // Input is held off for the whole flush
    a_flush_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) |-> !s_tready)
        else $error("input taken during flush");

    // Flush distance stays inside the window
    a_flush_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) |-> (flush_d_reg < k_eff))
        else $error("flush distance outside k-mer window");

    // Last flush step returns to run
    a_flush_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH && adv && flush_d_reg == 6'd0) |=> (state_reg == ST_RUN))
        else $error("flush did not end");

    // Island bounds are zero unless an island is reported on the last word
    a_island_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !(out_last_reg && out_found_reg)) |->
        (out_start_reg == 16'd0 && out_end_reg == 17'd0 && !out_found_reg))
        else $error("island fields set off the last word");

endmodule

`default_nettype wire

// ===== rtl/core/skc_cell.sv =====
// One cell of the coverage chain: holds a pending base and takes its
// neighbor's contents on each step. Depends on skc_pkg.
`default_nettype none

module skc_cell #(
    parameter int IDX = 0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire skc_pkg::cell_ctl_t ctl,
    input  wire logic [5:0]        k_eff,
    input  wire skc_pkg::cell_t    left,
    output skc_pkg::cell_t         upd,
    output skc_pkg::cell_t         q
);
    import skc_pkg::*;

    logic  hit;
    cell_t cell_reg;
    cell_t cell_next;

    // This cell lies inside the window of the newest k-mer
    assign hit = (6'(IDX) < k_eff);

    // Shifted value plus saturating coverage increment
    always_comb begin
        upd = left;
        if (ctl.inc_low && hit && (left.lcov != COVER_MAX)) begin
            upd.lcov = left.lcov + 6'd1;
        end
        if (ctl.inc_high && hit && (left.hcov != COVER_MAX)) begin
            upd.hcov = left.hcov + 6'd1;
        end
    end

    always_comb begin
        if (ctl.clear) begin
            cell_next = '0;
        end else if (ctl.step) begin
            cell_next = upd;
        end else begin
            cell_next = cell_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg <= '0;
        end else begin
            cell_reg <= cell_next;
        end
    end

    assign q = cell_reg;

endmodule

`default_nettype wire

// ===== rtl/core/skc_tap.sv =====
// Registered first level of the output tap: picks one group of eight cells
// of the chain by the upper tap bits. Depends on skc_pkg.
`default_nettype none

module skc_tap #(
    parameter int MAX_KMER = skc_pkg::MAX_KMER_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  en,
    input  wire logic [2:0]                            grp,
    input  wire skc_pkg::cell_t [MAX_KMER-1:0]         cells,
    output skc_pkg::cell_t [skc_pkg::LANES-1:0]        cand
);
    import skc_pkg::*;

    localparam int NGRP = (MAX_KMER + LANES - 1) / LANES;

    cell_t [LANES-1:0][NGRP-1:0] part;
    cell_t [LANES-1:0]           sel;
    cell_t [LANES-1:0]           cand_reg;

    // Gate each cell onto its lane when its group is chosen
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        for (genvar g = 0; g < NGRP; g++) begin : g_grp
            if (g * LANES + l < MAX_KMER) begin : g_cell
                assign part[l][g] = (grp == 3'(g)) ? cells[g * LANES + l] : '0;
            end else begin : g_none
                assign part[l][g] = '0;
            end
        end
    end

    // Merge the gated groups of each lane
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            sel[l] = '0;
            for (int g = 0; g < NGRP; g++) begin
                sel[l] = sel[l] | part[l][g];
            end
        end
    end

    // Hold candidates for the lane select in the output stage
    always_ff @(posedge aclk) begin
        if (en) begin
            cand_reg <= sel;
        end
    end

    assign cand = cand_reg;

endmodule

`default_nettype wire
